FILE: rtl/core/rect_polygon_collision_correction_unit_macros.svh
// Assertion macros for the box/polygon collision unit.
// Used by the top level only; expects signals clock and reset in scope.
`ifndef RECT_POLYGON_COLLISION_CORRECTION_UNIT_MACROS_SVH
`define RECT_POLYGON_COLLISION_CORRECTION_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define RPCC_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define RPCC_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/rpcc_pkg.sv
// Shared constants, codes and controller/datapath structs for the collision unit.
// No dependencies.
`timescale 1ns / 1ps
package rpcc_pkg;
   localparam int MAX_VERTICES = 16;
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int GW = 36;
   localparam int DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 6'd63;
   localparam logic [30:0] DEPTH_LIMIT_RESET = 31'd13107;

   localparam logic CSR_SPEED = 1'b0;
   localparam logic CSR_DEPTH_LIMIT = 1'b1;

   localparam logic [1:0] EDGE_TOP = 2'd0;
   localparam logic [1:0] EDGE_RIGHT = 2'd1;
   localparam logic [1:0] EDGE_BOTTOM = 2'd2;
   localparam logic [1:0] EDGE_LEFT = 2'd3;

   typedef struct packed {
      logic accept;
      logic rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic lat_c;
      logic lat_d;
      logic setup;
      logic [1:0] edge_sel;
      logic mul;
      logic div_step;
      logic eval;
      logic finish;
   } rpcc_cmd_type;

   typedef struct packed {
      logic skip;
      logic [CNT_W-1:0] count;
   } rpcc_status_type;
endpackage

FILE: rtl/core/rpcc_req_if.sv
// Request channel: box bounds and one polygon vertex per request.
// No dependencies.
`timescale 1ns / 1ps
interface rpcc_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] rect_left;
   logic signed [31:0] rect_top;
   logic [30:0] rect_width;
   logic [30:0] rect_height;
   logic signed [31:0] vertex_x;
   logic signed [31:0] vertex_y;
   logic last_vertex;
   modport source (output valid, rect_left, rect_top, rect_width, rect_height,
                   vertex_x, vertex_y, last_vertex, input ready);
   modport sink (input valid, rect_left, rect_top, rect_width, rect_height,
                 vertex_x, vertex_y, last_vertex, output ready);
endinterface

FILE: rtl/core/rpcc_rsp_if.sv
// Response channel: collision flag, vertical correction, truncation flag.
// No dependencies.
`timescale 1ns / 1ps
interface rpcc_rsp_if;
   logic valid;
   logic ready;
   logic collided;
   logic signed [31:0] correction_y;
   logic truncated;
   modport source (output valid, collided, correction_y, truncated, input ready);
   modport sink (input valid, collided, correction_y, truncated, output ready);
endinterface

FILE: rtl/core/rpcc_datapath.sv
// Datapath: vertex store, box and CSR registers, edge setup, multiplier,
// serial divider and hit/correction accumulation. Depends on rpcc_pkg.
`timescale 1ns / 1ps
module rpcc_datapath (
   input  logic clock,
   input  logic reset,
   input  rpcc_pkg::rpcc_cmd_type cmd,
   output rpcc_pkg::rpcc_status_type status,
   input  logic signed [31:0] rect_left,
   input  logic signed [31:0] rect_top,
   input  logic [30:0] rect_width,
   input  logic [30:0] rect_height,
   input  logic signed [31:0] vertex_x,
   input  logic signed [31:0] vertex_y,
   input  logic csr_write_en,
   input  logic csr_index,
   input  logic [30:0] csr_wdata,
   output logic collided,
   output logic signed [31:0] correction_y,
   output logic truncated
);
   localparam int GW = rpcc_pkg::GW;

   logic [63:0] mem [rpcc_pkg::MAX_VERTICES];
   logic [63:0] rdata_ff;
   logic [rpcc_pkg::CNT_W-1:0] count_ff, count_in;
   logic ovf_ff, ovf_in;
   logic signed [31:0] box_left_ff, box_top_ff;
   logic [30:0] box_w_ff, box_h_ff;
   logic [30:0] speed_ff, min_ov_ff;
   logic signed [31:0] cx_ff, cy_ff, dx_ff, dy_ff;

   logic signed [GW-1:0] right, bottom, left_w, top_w;
   logic signed [GW-1:0] kv, lo, hi, ak, am, bk, bm, ck, cm, dk, dm;
   logic signed [GW-1:0] s, p, delta, adelta;

   logic [31:0] s_ff, p_ff, ad_ff;
   logic neg_ff;
   logic [1:0] edge_ff;
   logic signed [GW-1:0] cm_ff, lo_m_ff, hi_m_ff;
   logic [63:0] mag_ff;
   logic [31:0] rem_ff, quo_ff;
   logic [32:0] trial;
   logic ge;

   logic signed [GW-1:0] q, fl, ce, mv, depth;
   logic signed [GW+1:0] corr_c;
   logic signed [31:0] corr_sat;
   logic rnz, hit_e;
   logic hit_ff, hit_in;
   logic signed [31:0] corr_ff, corr_in;

   assign left_w = {{(GW-32){box_left_ff[31]}}, box_left_ff};
   assign top_w = {{(GW-32){box_top_ff[31]}}, box_top_ff};
   assign right = left_w + GW'(box_w_ff);
   assign bottom = top_w + GW'(box_h_ff);

   always_comb begin
      kv = top_w;
      lo = left_w;
      hi = right;
      ak = {{(GW-32){cy_ff[31]}}, cy_ff};
      am = {{(GW-32){cx_ff[31]}}, cx_ff};
      bk = {{(GW-32){dy_ff[31]}}, dy_ff};
      bm = {{(GW-32){dx_ff[31]}}, dx_ff};
      unique case (cmd.edge_sel) inside
         rpcc_pkg::EDGE_TOP: kv = top_w;
         rpcc_pkg::EDGE_BOTTOM: kv = bottom;
         rpcc_pkg::EDGE_RIGHT, rpcc_pkg::EDGE_LEFT: begin
            kv = (cmd.edge_sel == rpcc_pkg::EDGE_RIGHT) ? right : left_w;
            lo = top_w;
            hi = bottom;
            ak = {{(GW-32){cx_ff[31]}}, cx_ff};
            am = {{(GW-32){cy_ff[31]}}, cy_ff};
            bk = {{(GW-32){dx_ff[31]}}, dx_ff};
            bm = {{(GW-32){dy_ff[31]}}, dy_ff};
         end
         default: kv = top_w;
      endcase
      if (bk < ak) begin
         ck = bk; cm = bm; dk = ak; dm = am;
      end else begin
         ck = ak; cm = am; dk = bk; dm = bm;
      end
      s = dk - ck;
      p = kv - ck;
      delta = dm - cm;
      adelta = delta[GW-1] ? -delta : delta;
      status.skip = (lo == hi) || (ck == dk) || (kv < ck) || (kv > dk);
      status.count = count_ff;
   end

   assign trial = {rem_ff, mag_ff[63]};
   assign ge = trial >= {1'b0, s_ff};

   always_comb begin
      q = GW'(quo_ff);
      rnz = |rem_ff;
      if (neg_ff) begin
         fl = -q - GW'(rnz);
         ce = -q;
      end else begin
         fl = q;
         ce = q + GW'(rnz);
      end
      hit_e = !((fl < lo_m_ff) || (ce > hi_m_ff));
      mv = cm_ff + fl;
      case (edge_ff)
         rpcc_pkg::EDGE_TOP: depth = GW'(box_h_ff);
         rpcc_pkg::EDGE_BOTTOM: depth = '0;
         default: depth = bottom - mv;
      endcase
      corr_c = -(GW+2)'(depth) - (GW+2)'(speed_ff);
      if (corr_c < -(GW+2)'(64'sh80000000))
         corr_sat = 32'sh80000000;
      else
         corr_sat = corr_c[31:0];
   end

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      hit_in = hit_ff;
      corr_in = corr_ff;
      if (cmd.accept) begin
         if (count_ff < rpcc_pkg::CNT_W'(rpcc_pkg::MAX_VERTICES))
            count_in = count_ff + 1'b1;
         else
            ovf_in = 1'b1;
      end
      if (cmd.eval && hit_e) begin
         hit_in = 1'b1;
         if (depth > GW'(min_ov_ff) && corr_sat < corr_ff)
            corr_in = corr_sat;
      end
      if (cmd.finish) begin
         count_in = '0;
         ovf_in = 1'b0;
         hit_in = 1'b0;
         corr_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         hit_ff <= 1'b0;
         corr_ff <= '0;
         box_left_ff <= '0;
         box_top_ff <= '0;
         box_w_ff <= '0;
         box_h_ff <= '0;
         speed_ff <= '0;
         min_ov_ff <= rpcc_pkg::DEPTH_LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         hit_ff <= hit_in;
         corr_ff <= corr_in;
         if (cmd.accept && count_ff == '0) begin
            box_left_ff <= rect_left;
            box_top_ff <= rect_top;
            box_w_ff <= rect_width;
            box_h_ff <= rect_height;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               rpcc_pkg::CSR_SPEED: speed_ff <= csr_wdata;
               rpcc_pkg::CSR_DEPTH_LIMIT: min_ov_ff <= csr_wdata;
               default: speed_ff <= speed_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && count_ff < rpcc_pkg::CNT_W'(rpcc_pkg::MAX_VERTICES))
         mem[count_ff[rpcc_pkg::ADDR_W-1:0]] <= {vertex_x, vertex_y};
      if (cmd.rd_en)
         rdata_ff <= mem[cmd.rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.lat_c) begin
         cx_ff <= rdata_ff[63:32];
         cy_ff <= rdata_ff[31:0];
      end
      if (cmd.lat_d) begin
         dx_ff <= rdata_ff[63:32];
         dy_ff <= rdata_ff[31:0];
      end
      if (cmd.setup) begin
         s_ff <= s[31:0];
         p_ff <= p[31:0];
         ad_ff <= adelta[31:0];
         neg_ff <= delta[GW-1];
         edge_ff <= cmd.edge_sel;
         cm_ff <= cm;
         lo_m_ff <= lo - cm;
         hi_m_ff <= hi - cm;
      end
      if (cmd.mul) begin
         mag_ff <= p_ff * ad_ff;
         rem_ff <= '0;
         quo_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? 32'(trial - {1'b0, s_ff}) : trial[31:0];
         quo_ff <= {quo_ff[30:0], ge};
         mag_ff <= {mag_ff[62:0], 1'b0};
      end
      if (cmd.finish) begin
         collided <= hit_ff;
         correction_y <= corr_ff;
         truncated <= ovf_ff;
      end
   end
endmodule

FILE: rtl/core/rpcc_ctrl.sv
// Controller: request intake, polygon edge / box edge sequencing,
// divider step count and response valid. Depends on rpcc_pkg.
`timescale 1ns / 1ps
module rpcc_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_last,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  rpcc_pkg::rpcc_status_type status,
   output rpcc_pkg::rpcc_cmd_type cmd
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RDC = 4'd1;
   localparam logic [3:0] S_RDD = 4'd2;
   localparam logic [3:0] S_LATD = 4'd3;
   localparam logic [3:0] S_SETUP = 4'd4;
   localparam logic [3:0] S_MUL = 4'd5;
   localparam logic [3:0] S_DIV = 4'd6;
   localparam logic [3:0] S_EVAL = 4'd7;
   localparam logic [3:0] S_NEXT = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [rpcc_pkg::ADDR_W-1:0] j_ff, j_in, k;
   logic [1:0] e_ff, e_in;
   logic [rpcc_pkg::DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [rpcc_pkg::CNT_W-1:0] j_next;
   logic last_j;

   assign j_next = {1'b0, j_ff} + 1'b1;
   assign last_j = j_next >= status.count;
   assign k = last_j ? '0 : j_next[rpcc_pkg::ADDR_W-1:0];
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      j_in = j_ff;
      e_in = e_ff;
      dcnt_in = dcnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd = '0;
      cmd.edge_sel = e_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_last) begin
               j_in = '0;
               state_in = S_RDC;
            end
         end
         S_RDC: begin
            cmd.rd_en = 1'b1;
            cmd.rd_addr = j_ff;
            state_in = S_RDD;
         end
         S_RDD: begin
            cmd.lat_c = 1'b1;
            cmd.rd_en = 1'b1;
            cmd.rd_addr = k;
            state_in = S_LATD;
         end
         S_LATD: begin
            cmd.lat_d = 1'b1;
            e_in = rpcc_pkg::EDGE_TOP;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in = status.skip ? S_NEXT : S_MUL;
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            dcnt_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == rpcc_pkg::DIV_LAST)
               state_in = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if (e_ff != rpcc_pkg::EDGE_LEFT) begin
               e_in = e_ff + 1'b1;
               state_in = S_SETUP;
            end else if (!last_j) begin
               j_in = j_next[rpcc_pkg::ADDR_W-1:0];
               state_in = S_RDC;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         j_ff <= '0;
         e_ff <= '0;
         dcnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         j_ff <= j_in;
         e_ff <= e_in;
         dcnt_ff <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: rtl/core/rect_polygon_collision_correction_unit.sv
// channel | dir | handshake   | payload
// req     | in  | valid/ready | box bounds, vertex, last_vertex
// rsp     | out | valid/ready | collided, correction_y, truncated
// csr     | in  | write_en    | index 0 speed, 1 depth threshold
// A non-final vertex request is accepted and stored while idle. For a final vertex request,
// the unit fetches each polygon edge of the V stored vertices, then runs
// per box edge setup, multiply, the 64-step serial divider, evaluate and advance.
// A box edge that the polygon edge cannot reach goes from setup straight to advance.
// Reset is synchronous; the vertex store needs no clearing.
// A waiting response holds the next final vertex in its last cycle and stalls requests.
`timescale 1ns / 1ps
`include "rect_polygon_collision_correction_unit_macros.svh"
module rect_polygon_collision_correction_unit (
   input  logic clock,
   input  logic reset,
   rpcc_req_if.sink req,
   rpcc_rsp_if.source rsp,
   input  logic csr_write_en,
   input  logic csr_index,
   input  logic [30:0] csr_wdata
);
   rpcc_pkg::rpcc_cmd_type cmd;
   rpcc_pkg::rpcc_status_type status;

   rpcc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_last(req.last_vertex),
      .req_ready(req.ready),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .status(status),
      .cmd(cmd)
   );

   rpcc_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .rect_left(req.rect_left),
      .rect_top(req.rect_top),
      .rect_width(req.rect_width),
      .rect_height(req.rect_height),
      .vertex_x(req.vertex_x),
      .vertex_y(req.vertex_y),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .collided(rsp.collided),
      .correction_y(rsp.correction_y),
      .truncated(rsp.truncated)
   );

   `RPCC_ASSERT_NEXT(a_busy_after_last, req.valid && req.ready && req.last_vertex, !req.ready, "ready after final vertex")
   `RPCC_ASSERT_ALWAYS(a_count_bound, status.count <= rpcc_pkg::CNT_W'(rpcc_pkg::MAX_VERTICES), "vertex count overflow")
   `RPCC_ASSERT_ALWAYS(a_corr_nonpos, !rsp.valid || rsp.correction_y[31] || rsp.correction_y == 32'sd0, "positive correction")
endmodule
